[rtl/pbpl_pkg.sv]
// Package of the page buffer pool with LRU replacement: shared types and codes.
// Used by pbpl_cell, page_buffer_pool_lru_core and pbpl_checker; depends on nothing.
package pbpl_pkg;

    // Width of the frame index fields on the ports.
    localparam int FRAME_W = 4;

    // Operation codes.
    localparam logic OP_RETRIEVE = 1'b0;
    localparam logic OP_RELEASE  = 1'b1;

    // Status codes.
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_FRAME = 1'b1;

    // Command broadcast from the core to every cell in the resolve cycle.
    typedef struct packed {
        logic touch;     // make the target frame the most recent and pin it
        logic load;      // load a new page into the target frame
        logic rel;       // release the target frame
        logic keep;      // release: pin value to write
        logic dirty;     // release: dirty bit to OR in
        logic was_valid; // target frame held a page before this word
    } t_cell_ctl;

endpackage

[rtl/page_buffer_pool_lru_core.sv]
// Top level of the page buffer pool with LRU replacement and pinning.
// Instantiates a chain of pbpl_cell frames; uses pbpl_pkg.
//
// Channel   Direction  Handshake                    Payload
// command   in         start high while busy low    i_op, i_page, i_frame, i_dirty, i_keep_pinned
// result    out        o_strobe high for one cycle   o_frame_out, o_hit, o_fetch, o_writeback,
//                                                    o_victim_page, o_status
//
// For each word: in the accept cycle each cell compares its tag with the
// page and marks whether it is the least recent unpinned frame; in the next cycle (busy)
// the chain resolves hit and victim, all cells update and the result is registered.
// The result strobe is high in the cycle after that, when a new word may already be taken.
// Synchronous active-low reset empties every frame; there is no clearing pass.
// The receiver cannot hold results off, so nothing in the block stalls.
module page_buffer_pool_lru_core #(
    parameter int SLOTS     = 16,
    parameter int PAGE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_op,
    input  logic [PAGE_BITS-1:0]          i_page,
    input  logic [pbpl_pkg::FRAME_W-1:0]  i_frame,
    input  logic                          i_dirty,
    input  logic                          i_keep_pinned,
    output logic                          o_strobe,
    output logic [pbpl_pkg::FRAME_W-1:0]  o_frame_out,
    output logic                          o_hit,
    output logic                          o_fetch,
    output logic                          o_writeback,
    output logic [PAGE_BITS-1:0]          o_victim_page,
    output logic                          o_status
);

    localparam int FW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int XW = FW + pbpl_pkg::FRAME_W;

    logic                         r_busy;
    logic                         r_op;
    logic [PAGE_BITS-1:0]         r_page;
    logic [pbpl_pkg::FRAME_W-1:0] r_frame;
    logic                         r_dirty;
    logic                         r_keep;
    logic [CW-1:0]                r_unused;

    logic                         r_strobe;
    logic [pbpl_pkg::FRAME_W-1:0] r_frame_out;
    logic                         r_hit;
    logic                         r_fetch;
    logic                         r_writeback;
    logic [PAGE_BITS-1:0]         r_victim_page;
    logic                         r_status;

    logic [pbpl_pkg::FRAME_W-1:0] n_frame_out;
    logic                         n_hit;
    logic                         n_fetch;
    logic                         n_writeback;
    logic [PAGE_BITS-1:0]         n_victim_page;
    logic                         n_status;

    logic                 accept;
    logic                 take_unused;
    pbpl_pkg::t_cell_ctl  ctl;
    logic [FW-1:0]        tgt;
    logic [FW-1:0]        old_rank;
    logic [FW-1:0]        max_rank;
    logic [CW-1:0]        unused_next;
    logic [XW-1:0]        rel_ext;
    logic [XW-1:0]        tgt_ext;

    logic [SLOTS-1:0]     pres_c   [SLOTS+1];
    logic                 hit_c    [SLOTS+1];
    logic [FW-1:0]        hidx_c   [SLOTS+1];
    logic [FW-1:0]        hrank_c  [SLOTS+1];
    logic                 vic_c    [SLOTS+1];
    logic [FW-1:0]        vidx_c   [SLOTS+1];
    logic [FW-1:0]        vrank_c  [SLOTS+1];
    logic                 vdirty_c [SLOTS+1];
    logic [PAGE_BITS-1:0] vpage_c  [SLOTS+1];

    assign accept = start && !r_busy;
    assign busy   = r_busy;

    assign pres_c[0]   = '0;
    assign hit_c[0]    = 1'b0;
    assign hidx_c[0]   = '0;
    assign hrank_c[0]  = '0;
    assign vic_c[0]    = 1'b0;
    assign vidx_c[0]   = '0;
    assign vrank_c[0]  = '0;
    assign vdirty_c[0] = 1'b0;
    assign vpage_c[0]  = '0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        pbpl_cell #(
            .SLOTS     (SLOTS),
            .PAGE_BITS (PAGE_BITS),
            .IDX       (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_capture   (accept),
            .i_req_page  (i_page),
            .i_max_rank  (max_rank),
            .i_ctl       (ctl),
            .i_tgt       (tgt),
            .i_old_rank  (old_rank),
            .i_load_page (r_page),
            .i_pres      (pres_c[g]),
            .o_pres      (pres_c[g+1]),
            .i_hit       (hit_c[g]),
            .i_hit_idx   (hidx_c[g]),
            .i_hit_rank  (hrank_c[g]),
            .o_hit       (hit_c[g+1]),
            .o_hit_idx   (hidx_c[g+1]),
            .o_hit_rank  (hrank_c[g+1]),
            .i_vic       (vic_c[g]),
            .i_vic_idx   (vidx_c[g]),
            .i_vic_rank  (vrank_c[g]),
            .i_vic_dirty (vdirty_c[g]),
            .i_vic_page  (vpage_c[g]),
            .o_vic       (vic_c[g+1]),
            .o_vic_idx   (vidx_c[g+1]),
            .o_vic_rank  (vrank_c[g+1]),
            .o_vic_dirty (vdirty_c[g+1]),
            .o_vic_page  (vpage_c[g+1])
        );
    end

    // Highest rank held by an unpinned valid frame.
    always_comb begin
        max_rank = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (pres_c[SLOTS][i]) begin
                max_rank = FW'(i);
            end
        end
    end

    assign unused_next = r_unused - CW'(1);
    assign rel_ext     = {{FW{1'b0}}, r_frame};
    assign tgt_ext     = {{pbpl_pkg::FRAME_W{1'b0}}, tgt};

    always_comb begin
        ctl           = '0;
        tgt           = '0;
        old_rank      = '0;
        take_unused   = 1'b0;
        n_frame_out   = '0;
        n_hit         = 1'b0;
        n_fetch       = 1'b0;
        n_writeback   = 1'b0;
        n_victim_page = '0;
        n_status      = pbpl_pkg::STATUS_OK;
        if (r_busy) begin
            if (r_op == pbpl_pkg::OP_RELEASE) begin
                n_frame_out = r_frame;
                if (32'(r_frame) < SLOTS) begin
                    ctl.rel   = 1'b1;
                    ctl.keep  = r_keep;
                    ctl.dirty = r_dirty;
                    tgt       = rel_ext[FW-1:0];
                end
            end else if (hit_c[SLOTS]) begin
                ctl.touch     = 1'b1;
                ctl.was_valid = 1'b1;
                tgt           = hidx_c[SLOTS];
                old_rank      = hrank_c[SLOTS];
                n_frame_out   = tgt_ext[pbpl_pkg::FRAME_W-1:0];
                n_hit         = 1'b1;
            end else if (r_unused != '0) begin
                ctl.touch   = 1'b1;
                ctl.load    = 1'b1;
                take_unused = 1'b1;
                tgt         = unused_next[FW-1:0];
                n_frame_out = tgt_ext[pbpl_pkg::FRAME_W-1:0];
                n_fetch     = 1'b1;
            end else if (vic_c[SLOTS]) begin
                ctl.touch     = 1'b1;
                ctl.load      = 1'b1;
                ctl.was_valid = 1'b1;
                tgt           = vidx_c[SLOTS];
                old_rank      = vrank_c[SLOTS];
                n_frame_out   = tgt_ext[pbpl_pkg::FRAME_W-1:0];
                n_fetch       = 1'b1;
                n_writeback   = vdirty_c[SLOTS];
                n_victim_page = vdirty_c[SLOTS] ? vpage_c[SLOTS] : '0;
            end else begin
                n_status = pbpl_pkg::STATUS_NO_FRAME;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
            r_unused <= CW'(SLOTS);
        end else begin
            r_busy   <= accept;
            r_strobe <= r_busy;
            if (take_unused) begin
                r_unused <= unused_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_op;
            r_page  <= i_page;
            r_frame <= i_frame;
            r_dirty <= i_dirty;
            r_keep  <= i_keep_pinned;
        end
        if (r_busy) begin
            r_frame_out   <= n_frame_out;
            r_hit         <= n_hit;
            r_fetch       <= n_fetch;
            r_writeback   <= n_writeback;
            r_victim_page <= n_victim_page;
            r_status      <= n_status;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_frame_out   = r_frame_out;
    assign o_hit         = r_hit;
    assign o_fetch       = r_fetch;
    assign o_writeback   = r_writeback;
    assign o_victim_page = r_victim_page;
    assign o_status      = r_status;

endmodule

[rtl/pbpl_cell.sv]
// One frame cell of the buffer pool: page tag, valid, recency rank, pin and dirty.
// Cells form a chain carrying rank presence, hit and victim data; uses pbpl_pkg.
module pbpl_cell #(
    parameter int SLOTS     = 16,
    parameter int PAGE_BITS = 24,
    parameter int IDX       = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_capture,
    input  logic [PAGE_BITS-1:0]    i_req_page,
    input  logic [$clog2(SLOTS)-1:0] i_max_rank,
    input  pbpl_pkg::t_cell_ctl     i_ctl,
    input  logic [$clog2(SLOTS)-1:0] i_tgt,
    input  logic [$clog2(SLOTS)-1:0] i_old_rank,
    input  logic [PAGE_BITS-1:0]    i_load_page,
    input  logic [SLOTS-1:0]        i_pres,
    output logic [SLOTS-1:0]        o_pres,
    input  logic                    i_hit,
    input  logic [$clog2(SLOTS)-1:0] i_hit_idx,
    input  logic [$clog2(SLOTS)-1:0] i_hit_rank,
    output logic                    o_hit,
    output logic [$clog2(SLOTS)-1:0] o_hit_idx,
    output logic [$clog2(SLOTS)-1:0] o_hit_rank,
    input  logic                    i_vic,
    input  logic [$clog2(SLOTS)-1:0] i_vic_idx,
    input  logic [$clog2(SLOTS)-1:0] i_vic_rank,
    input  logic                    i_vic_dirty,
    input  logic [PAGE_BITS-1:0]    i_vic_page,
    output logic                    o_vic,
    output logic [$clog2(SLOTS)-1:0] o_vic_idx,
    output logic [$clog2(SLOTS)-1:0] o_vic_rank,
    output logic                    o_vic_dirty,
    output logic [PAGE_BITS-1:0]    o_vic_page
);

    localparam int FW = $clog2(SLOTS);
    localparam logic [FW-1:0] MY_IDX = FW'(IDX);

    logic [PAGE_BITS-1:0] r_page;
    logic                 r_valid;
    logic [FW-1:0]        r_rank;
    logic                 r_pinned;
    logic                 r_dirty;
    logic                 r_match;
    logic                 r_is_vic;

    logic eligible;
    logic is_tgt;
    logic hit_sel;

    assign eligible = r_valid && !r_pinned;
    assign is_tgt   = (i_tgt == MY_IDX);

    // Each eligible frame marks its rank; the core picks the highest marked rank.
    assign o_pres = i_pres | (eligible ? (SLOTS'(1) << r_rank) : '0);

    // First matching frame along the chain wins.
    assign hit_sel    = r_match && !i_hit;
    assign o_hit      = i_hit || r_match;
    assign o_hit_idx  = hit_sel ? MY_IDX : i_hit_idx;
    assign o_hit_rank = hit_sel ? r_rank : i_hit_rank;

    // Ranks are distinct, so at most one cell flags itself as the victim.
    assign o_vic       = i_vic || r_is_vic;
    assign o_vic_idx   = r_is_vic ? MY_IDX  : i_vic_idx;
    assign o_vic_rank  = r_is_vic ? r_rank  : i_vic_rank;
    assign o_vic_dirty = r_is_vic ? r_dirty : i_vic_dirty;
    assign o_vic_page  = r_is_vic ? r_page  : i_vic_page;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_rank   <= '0;
            r_pinned <= 1'b0;
            r_dirty  <= 1'b0;
            r_match  <= 1'b0;
            r_is_vic <= 1'b0;
        end else begin
            if (i_capture) begin
                r_match  <= r_valid && (r_page == i_req_page);
                r_is_vic <= eligible && (r_rank == i_max_rank);
            end
            if (i_ctl.touch) begin
                if (is_tgt) begin
                    r_rank   <= '0;
                    r_pinned <= 1'b1;
                end else if (r_valid && (!i_ctl.was_valid || r_rank < i_old_rank)) begin
                    r_rank <= r_rank + FW'(1);
                end
            end
            if (i_ctl.load && is_tgt) begin
                r_valid <= 1'b1;
                r_dirty <= 1'b0;
            end
            if (i_ctl.rel && is_tgt) begin
                r_pinned <= i_ctl.keep;
                r_dirty  <= r_dirty || i_ctl.dirty;
            end
        end
    end

    // The page tag needs no reset: it is only compared while the frame is valid.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load && is_tgt) begin
            r_page <= i_load_page;
        end
    end

endmodule

[rtl/pbpl_checker.sv]
// Port-level checks for the page buffer pool, bound to page_buffer_pool_lru_core.
// Uses pbpl_pkg for the status code.
module pbpl_checker #(
    parameter int PAGE_BITS = 24
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_strobe,
    input logic [pbpl_pkg::FRAME_W-1:0]  o_frame_out,
    input logic                          o_hit,
    input logic                          o_fetch,
    input logic                          o_writeback,
    input logic [PAGE_BITS-1:0]          o_victim_page,
    input logic                          o_status
);

    // A taken word keeps the block busy for exactly one cycle, then the result shows.
    a_word_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_strobe && !busy))
        else $error("result did not follow a busy cycle");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // A hit never needs a fetch, and only a fetch can evict.
    a_hit_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (!(o_hit && o_fetch) && (o_fetch || !o_writeback)))
        else $error("inconsistent hit, fetch and writeback flags");

    a_victim_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_writeback) |-> (o_victim_page == '0))
        else $error("victim page shown without writeback");

    a_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == pbpl_pkg::STATUS_NO_FRAME)) |->
        ((o_frame_out == '0) && !o_hit && !o_fetch))
        else $error("error result carries a frame");

endmodule

bind page_buffer_pool_lru_core pbpl_checker #(
    .PAGE_BITS (PAGE_BITS)
) u_pbpl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_strobe      (o_strobe),
    .o_frame_out   (o_frame_out),
    .o_hit         (o_hit),
    .o_fetch       (o_fetch),
    .o_writeback   (o_writeback),
    .o_victim_page (o_victim_page),
    .o_status      (o_status)
);

[tb/sv/page_buffer_pool_lru_core_tb.sv]
// Self-checking testbench for page_buffer_pool_lru_core: directed and random words.
// Holds its own model of the frame pool; depends on pbpl_pkg and the RTL only.
module page_buffer_pool_lru_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = 16;
    localparam int PAGE_BITS   = 24;
    localparam int HALF_PERIOD = 10;
    localparam int HOT_PAGES   = 32;
    localparam int STALL_LIMIT = 4000;
    localparam int SHOWN_ERRORS = 10;

    typedef struct packed {
        logic [pbpl_pkg::FRAME_W-1:0] frame_out;
        logic                         hit;
        logic                         fetch;
        logic                         writeback;
        logic [PAGE_BITS-1:0]         victim_page;
        logic                         status;
    } t_pool_reply;

    logic                         i_clk         = 1'b0;
    logic                         i_rst_n       = 1'b0;
    logic                         start         = 1'b0;
    logic                         busy;
    logic                         i_op          = pbpl_pkg::OP_RETRIEVE;
    logic [PAGE_BITS-1:0]         i_page        = '0;
    logic [pbpl_pkg::FRAME_W-1:0] i_frame       = '0;
    logic                         i_dirty       = 1'b0;
    logic                         i_keep_pinned = 1'b0;
    logic                         o_strobe;
    logic [pbpl_pkg::FRAME_W-1:0] o_frame_out;
    logic                         o_hit;
    logic                         o_fetch;
    logic                         o_writeback;
    logic [PAGE_BITS-1:0]         o_victim_page;
    logic                         o_status;

    // Shadow copy of the frame pool.
    logic [PAGE_BITS-1:0]         frame_tag   [SLOTS];
    logic                         frame_held  [SLOTS] = '{default: 1'b0};
    logic [pbpl_pkg::FRAME_W-1:0] frame_rank  [SLOTS] = '{default: '0};
    logic                         frame_pin   [SLOTS] = '{default: 1'b0};
    logic                         frame_dirty [SLOTS] = '{default: 1'b0};
    int                           fresh_frame = SLOTS - 1;

    t_pool_reply          replies_due[$];
    logic [PAGE_BITS-1:0] hot_pages[HOT_PAGES];
    int                   sender_idle_pct = 13;
    int                   mismatches = 0;
    int                   quiet_cycles = 0;

    page_buffer_pool_lru_core #(
        .SLOTS     (SLOTS),
        .PAGE_BITS (PAGE_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_page        (i_page),
        .i_frame       (i_frame),
        .i_dirty       (i_dirty),
        .i_keep_pinned (i_keep_pinned),
        .o_strobe      (o_strobe),
        .o_frame_out   (o_frame_out),
        .o_hit         (o_hit),
        .o_fetch       (o_fetch),
        .o_writeback   (o_writeback),
        .o_victim_page (o_victim_page),
        .o_status      (o_status)
    );

    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    // A frame that held no page counts as older than every valid one.
    function automatic void promote_frame(input int f);
        logic                         was_held;
        logic [pbpl_pkg::FRAME_W-1:0] old_rank;
        was_held = frame_held[f];
        old_rank = frame_rank[f];
        for (int i = 0; i < SLOTS; i++) begin
            if (i != f && frame_held[i] && (!was_held || frame_rank[i] < old_rank)) begin
                frame_rank[i] = frame_rank[i] + 1'b1;
            end
        end
        frame_rank[f] = '0;
    endfunction

    function automatic t_pool_reply pool_outcome(input logic op,
                                                 input logic [PAGE_BITS-1:0] page,
                                                 input logic [pbpl_pkg::FRAME_W-1:0] frame,
                                                 input logic dirty,
                                                 input logic keep);
        t_pool_reply reply;
        int          slot;
        int          victim;
        logic        found;
        reply  = '0;
        slot   = 0;
        victim = -1;
        found  = 1'b0;
        if (op == pbpl_pkg::OP_RELEASE) begin
            if (frame < SLOTS) begin
                frame_pin[frame]   = keep;
                frame_dirty[frame] = frame_dirty[frame] | dirty;
            end
            reply.frame_out = frame;
            reply.status    = pbpl_pkg::STATUS_OK;
            return reply;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (!found && frame_held[i] && frame_tag[i] == page) begin
                found = 1'b1;
                slot  = i;
            end
        end
        if (found) begin
            promote_frame(slot);
            frame_pin[slot] = 1'b1;
            reply.frame_out = slot[pbpl_pkg::FRAME_W-1:0];
            reply.hit       = 1'b1;
            return reply;
        end
        if (fresh_frame >= 0) begin
            slot        = fresh_frame;
            fresh_frame = fresh_frame - 1;
        end else begin
            for (int i = 0; i < SLOTS; i++) begin
                if (frame_held[i] && !frame_pin[i] &&
                    (victim < 0 || frame_rank[i] > frame_rank[victim])) begin
                    victim = i;
                end
            end
            if (victim < 0) begin
                reply.status = pbpl_pkg::STATUS_NO_FRAME;
                return reply;
            end
            slot = victim;
            if (frame_dirty[slot]) begin
                reply.writeback   = 1'b1;
                reply.victim_page = frame_tag[slot];
            end
        end
        promote_frame(slot);
        frame_held[slot]  = 1'b1;
        frame_tag[slot]   = page;
        frame_dirty[slot] = 1'b0;
        frame_pin[slot]   = 1'b1;
        reply.frame_out   = slot[pbpl_pkg::FRAME_W-1:0];
        reply.fetch       = 1'b1;
        return reply;
    endfunction

    // Presents one word, holds it until the block takes it, and records the
    // reply it must produce. Start stays high when words follow back to back.
    task automatic send_word(input logic op, input logic [PAGE_BITS-1:0] page,
                             input logic [pbpl_pkg::FRAME_W-1:0] frame, input logic dirty,
                             input logic keep);
        t_pool_reply reply;
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        start         <= 1'b1;
        i_op          <= op;
        i_page        <= page;
        i_frame       <= frame;
        i_dirty       <= dirty;
        i_keep_pinned <= keep;
        do @(posedge i_clk); while (busy);
        reply       = pool_outcome(op, page, frame, dirty, keep);
        replies_due = {replies_due, reply};
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= SHOWN_ERRORS) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_pool_reply want;
        if (i_rst_n && o_strobe) begin
            if (replies_due.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS) begin
                    $display("%0t: result word with none outstanding, frame %0d",
                             $realtime, o_frame_out);
                end
            end else begin
                want = replies_due.pop_front();
                check_field("frame_out",   want.frame_out,   o_frame_out);
                check_field("hit",         want.hit,         o_hit);
                check_field("fetch",       want.fetch,       o_fetch);
                check_field("writeback",   want.writeback,   o_writeback);
                check_field("victim_page", want.victim_page, o_victim_page);
                check_field("status",      want.status,      o_status);
            end
        end
    end

    // Ends the run if neither a command nor a result moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Fills every frame from the top down, with both page extremes, a hit,
    // and releases of a loaded frame and of one that holds no page yet.
    task automatic test_fill_and_hit();
        send_word(pbpl_pkg::OP_RETRIEVE, 24'h000000, 4'h0, 1'b0, 1'b0);
        send_word(pbpl_pkg::OP_RETRIEVE, 24'hFFFFFF, 4'hF, 1'b1, 1'b1);
        send_word(pbpl_pkg::OP_RETRIEVE, 24'h000000, 4'h0, 1'b0, 1'b0);
        send_word(pbpl_pkg::OP_RELEASE,  24'h000000, 4'hF, 1'b1, 1'b0);
        send_word(pbpl_pkg::OP_RELEASE,  24'hFFFFFF, 4'hE, 1'b0, 1'b1);
        send_word(pbpl_pkg::OP_RELEASE,  24'h000000, 4'h3, 1'b1, 1'b1);
        for (int k = 1; k <= 14; k++) begin
            send_word(pbpl_pkg::OP_RETRIEVE, PAGE_BITS'((k << 16) | (k << 4) | 1), 4'(k),
                      1'b0, 1'b0);
        end
    endtask

    // With the pool full: a dirty eviction, the all-pinned error, then a
    // clean eviction after one frame is let go, and a final hit.
    task automatic test_eviction_and_pinning();
        send_word(pbpl_pkg::OP_RETRIEVE, 24'hA5A5A5, 4'h0, 1'b0, 1'b0);
        send_word(pbpl_pkg::OP_RETRIEVE, 24'h5A5A5A, 4'h0, 1'b0, 1'b0);
        send_word(pbpl_pkg::OP_RELEASE,  24'h000000, 4'h2, 1'b0, 1'b0);
        send_word(pbpl_pkg::OP_RETRIEVE, 24'h5A5A5A, 4'h0, 1'b0, 1'b0);
        send_word(pbpl_pkg::OP_RETRIEVE, 24'hFFFFFF, 4'h0, 1'b0, 1'b0);
    endtask

    // Pages come mostly from a small set so that hits, evictions and
    // write-backs all recur; the rest are fully random.
    task automatic test_random_traffic(input int words, input int idle_pct,
                                       input int release_pct);
        logic [PAGE_BITS-1:0] page;
        sender_idle_pct = idle_pct;
        repeat (words) begin
            page = ($urandom_range(99) < 85) ? hot_pages[$urandom_range(HOT_PAGES - 1)]
                                             : PAGE_BITS'($urandom);
            if ($urandom_range(99) < release_pct) begin
                send_word(pbpl_pkg::OP_RELEASE, page,
                          pbpl_pkg::FRAME_W'($urandom_range(SLOTS - 1)),
                          1'($urandom_range(1)), $urandom_range(99) < 25);
            end else begin
                send_word(pbpl_pkg::OP_RETRIEVE, page,
                          pbpl_pkg::FRAME_W'($urandom_range(SLOTS - 1)),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        hot_pages[0] = '0;
        hot_pages[1] = '1;
        for (int k = 2; k < HOT_PAGES; k++) begin
            hot_pages[k] = PAGE_BITS'($urandom);
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_fill_and_hit();
        test_eviction_and_pinning();
        test_random_traffic(430, 13, 45);
        test_random_traffic(430, 88, 35);
        test_random_traffic(440, 0, 50);

        start <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
